// ===== rtl/srte_pkg.sv =====
// Shared types, register indexes and level arithmetic for the sensor envelope unit.
package srte_pkg;

    // Default sensor count
    localparam int SRTE_NUM_SENSORS = 64;

    // Field widths
    localparam int SENSOR_ID_W = 6;
    localparam int INDEX_W     = 8;
    localparam int TIME_W      = 16;
    localparam int LEVEL_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_INDEX     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RISE_STEP     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [INDEX_W-1:0] MAX_INDEX_RST     = 8'd10;
    localparam logic [TIME_W-1:0]  TIMEOUT_TICKS_RST = 16'd100;
    localparam logic [LEVEL_W-1:0] RISE_STEP_RST     = 16'd6553;

    // Full-scale level, Q0.16
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 16'hFFFF;

    // Per-sensor state word
    typedef struct packed {
        logic [INDEX_W-1:0] ramp_index;
        logic [TIME_W-1:0]  high_time;
        logic [LEVEL_W-1:0] held_level;
    } entry_t;

    // Level of a ramp index: index times step saturated to full scale, full scale at or past the ramp end
    function automatic logic [LEVEL_W-1:0] level_of(
        input logic [INDEX_W-1:0] idx,
        input logic [INDEX_W-1:0] max_idx,
        input logic [LEVEL_W-1:0] step
    );
        logic [INDEX_W+LEVEL_W-1:0] prod;
        prod = {{LEVEL_W{1'b0}}, idx} * {{INDEX_W{1'b0}}, step};
        if (idx >= max_idx) begin
            level_of = LEVEL_FULL;
        end else if (prod[INDEX_W+LEVEL_W-1:LEVEL_W] != '0) begin
            level_of = LEVEL_FULL;
        end else begin
            level_of = prod[LEVEL_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/sensor_rise_timeout_envelope_unit.sv =====
// Per-sensor rise/timeout brightness envelope: state memory, update logic and result register.
// Takes one sensor sample per clock when the result side does not stall, and returns one level
// beat per sample, in order, from the update stage through the result register. The rate is set
// by the single read-modify-write of the per-sensor state memory (synchronous read at
// accept, update and write when the sample advances, with the last write forwarded to a following
// sample of the same sensor). Reset clears all sensor state at once through per-entry valid
// bits, so samples are taken from the first cycle after reset. A sensor id at or above
// NUM_SENSORS changes no state and reports level zero. Configuration writes are taken at any
// time (cfg_ready is always high) but must only be issued while no sample is in flight.
module sensor_rise_timeout_envelope_unit
    import srte_pkg::*;
#(
    parameter int NUM_SENSORS = SRTE_NUM_SENSORS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Sample channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [5:0] sensor_id, [6] sample_high, [7] zero
    // Level channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [5:0] level_sensor_id, [21:6] level, [23:22] zero
    // Configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Only sensor ids that fit the id field can ever be addressed
    localparam int ID_SPAN = 1 << SENSOR_ID_W;
    localparam int DEPTH   = (NUM_SENSORS < ID_SPAN) ? NUM_SENSORS : ID_SPAN;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration registers
    logic [INDEX_W-1:0] max_index_reg;
    logic [TIME_W-1:0]  timeout_ticks_reg;
    logic [LEVEL_W-1:0] rise_step_reg;

    // State memory and its valid bits
    entry_t             mem [DEPTH];
    entry_t             rd_data_reg;
    logic [DEPTH-1:0]   vld_reg;

    // Update stage
    logic                   s1_valid_reg;
    logic [SENSOR_ID_W-1:0] s1_id_reg;
    logic                   s1_high_reg;

    // Last written entry, for forwarding
    logic                   byp_valid_reg;
    logic [SENSOR_ID_W-1:0] byp_id_reg;
    entry_t                 byp_data_reg;

    // Result register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                   s_accept;
    logic                   advance;
    logic [SENSOR_ID_W-1:0] s_id;
    logic                   in_range;
    logic                   mem_we;
    entry_t                 cur;
    entry_t                 upd;
    logic [INDEX_W-1:0]     idx_down;
    logic [LEVEL_W-1:0]     lvl;
    logic [LEVEL_W-1:0]     out_level;

    assign s_id      = s_tdata[SENSOR_ID_W-1:0];
    assign advance   = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign in_range  = 32'(s1_id_reg) < NUM_SENSORS;
    assign mem_we    = advance && in_range;
    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_index_reg     <= MAX_INDEX_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
            rise_step_reg     <= RISE_STEP_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_INDEX:     max_index_reg     <= cfg_data[INDEX_W-1:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[TIME_W-1:0];
                REG_RISE_STEP:     rise_step_reg     <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Read the sensor's state on the accepted beat
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= mem[s_id[AW-1:0]];
        end
    end

    // Write back the updated state
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[s1_id_reg[AW-1:0]] <= upd;
        end
    end

    // Valid bits and forwarding register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            byp_valid_reg <= 1'b0;
        end else if (mem_we) begin
            vld_reg[s1_id_reg[AW-1:0]] <= 1'b1;
            byp_valid_reg              <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            byp_id_reg   <= s1_id_reg;
            byp_data_reg <= upd;
        end
    end

    // Advance the sample into the update stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_id_reg   <= s_id;
            s1_high_reg <= s_tdata[SENSOR_ID_W];
        end
    end

    // Pick current state: forwarded write, stored entry, or reset value
    always_comb begin
        if (byp_valid_reg && (byp_id_reg == s1_id_reg)) begin
            cur = byp_data_reg;
        end else if (in_range && vld_reg[s1_id_reg[AW-1:0]]) begin
            cur = rd_data_reg;
        end else begin
            cur = '0;
        end
    end

    // Envelope update
    always_comb begin
        idx_down = (cur.ramp_index != '0) ? cur.ramp_index - INDEX_W'(1) : cur.ramp_index;
        lvl      = '0;
        upd      = cur;
        if (s1_high_reg) begin
            if (cur.high_time < timeout_ticks_reg) begin
                // Rising: report current index, then step up
                lvl            = level_of(cur.ramp_index, max_index_reg, rise_step_reg);
                upd.high_time  = cur.high_time + TIME_W'(1);
                if (cur.ramp_index < max_index_reg) begin
                    upd.ramp_index = cur.ramp_index + INDEX_W'(1);
                end
            end else begin
                // Timed out: step down, then report
                lvl            = level_of(idx_down, max_index_reg, rise_step_reg);
                upd.ramp_index = idx_down;
            end
            upd.held_level = lvl;
        end else begin
            // Low sample: restart the ramp, hold the level
            upd.ramp_index = '0;
            upd.high_time  = '0;
        end
        out_level = in_range ? upd.held_level : '0;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= {2'b00, out_level, s1_id_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A stalled update stage holds its sample
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_id_reg))
        else $error("update stage lost its sample while stalled");

    // Out-of-range sensors report level zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_range |=> m_tdata_reg[SENSOR_ID_W+LEVEL_W-1:SENSOR_ID_W] == '0)
        else $error("out-of-range sensor reported a nonzero level");

    // Forwarding register tracks the last write
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> byp_valid_reg && (byp_id_reg == $past(s1_id_reg)))
        else $error("forwarding register missed a state write");

    // Each advance loads a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid_reg && (m_tdata_reg[SENSOR_ID_W-1:0] == $past(s1_id_reg)))
        else $error("result register did not take the advancing sample");

endmodule

// ===== sim/srte_checker.sv =====
// Scoreboard for the sensor envelope unit: tracks per-sensor state, predicts and compares levels.
`timescale 1ns / 100ps

module srte_checker
    import srte_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [5:0] sensor_id, [6] sample_high, [7] zero
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,   // [5:0] level_sensor_id, [21:6] level, [23:22] zero
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int unsigned            fail_count,
    output int unsigned            levels_pending
);

    typedef struct packed {
        logic [SENSOR_ID_W-1:0] sensor;
        logic [LEVEL_W-1:0]     level;
    } level_beat_t;

    // Shadow copy of the per-sensor state and the register file
    logic [INDEX_W-1:0] ramp_idx   [SRTE_NUM_SENSORS];
    logic [TIME_W-1:0]  high_ticks [SRTE_NUM_SENSORS];
    logic [LEVEL_W-1:0] held_lvl   [SRTE_NUM_SENSORS];
    logic [INDEX_W-1:0] max_idx_reg;
    logic [TIME_W-1:0]  timeout_reg;
    logic [LEVEL_W-1:0] step_reg;

    level_beat_t expected_levels[$];

    initial begin
        fail_count     = 0;
        levels_pending = 0;
    end

    // Level of a ramp position: full scale at or past the ramp end, saturate the product
    function automatic logic [LEVEL_W-1:0] ramp_level(input logic [INDEX_W-1:0] idx);
        logic [INDEX_W+LEVEL_W-1:0] prod;
        prod = {{LEVEL_W{1'b0}}, idx} * {{INDEX_W{1'b0}}, step_reg};
        if (idx >= max_idx_reg) begin
            return LEVEL_FULL;
        end
        if (prod > {{INDEX_W{1'b0}}, LEVEL_FULL}) begin
            return LEVEL_FULL;
        end
        return prod[LEVEL_W-1:0];
    endfunction

    // Apply one sample to the shadow state and return the level beat it produces
    function automatic level_beat_t envelope_step(input logic [SENSOR_ID_W-1:0] id,
                                                  input logic is_high);
        logic [INDEX_W-1:0] idx;
        logic [TIME_W-1:0]  ht;
        level_beat_t        beat;
        beat.sensor = id;
        if (is_high) begin
            idx = ramp_idx[id];
            ht  = high_ticks[id];
            if (ht < timeout_reg) begin
                // rising: report the current step, then advance
                held_lvl[id] = ramp_level(idx);
                if (idx < max_idx_reg) begin
                    idx = idx + INDEX_W'(1);
                end
                ht = ht + TIME_W'(1);
            end else begin
                // timed out: step down first, then report
                if (idx != '0) begin
                    idx = idx - INDEX_W'(1);
                end
                held_lvl[id] = ramp_level(idx);
            end
            ramp_idx[id]   = idx;
            high_ticks[id] = ht;
        end else begin
            ramp_idx[id]   = '0;
            high_ticks[id] = '0;
        end
        beat.level = held_lvl[id];
        return beat;
    endfunction

    always @(posedge aclk) begin : track
        level_beat_t want;
        int unsigned errs;
        errs = 0;
        if (!aresetn) begin
            for (int i = 0; i < SRTE_NUM_SENSORS; i++) begin
                ramp_idx[i]   = '0;
                high_ticks[i] = '0;
                held_lvl[i]   = '0;
            end
            max_idx_reg = MAX_INDEX_RST;
            timeout_reg = TIMEOUT_TICKS_RST;
            step_reg    = RISE_STEP_RST;
            expected_levels.delete();
        end else begin
            // Compare a level beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_levels.size() == 0) begin
                    $error("level beat with no sample outstanding: tdata 0x%06h", m_tdata);
                    errs++;
                end else begin
                    want = expected_levels.pop_front();
                    if (m_tdata[SENSOR_ID_W-1:0] !== want.sensor) begin
                        $error("level_sensor_id mismatch: expected %0d, actual %0d",
                               want.sensor, m_tdata[SENSOR_ID_W-1:0]);
                        errs++;
                    end
                    if (m_tdata[SENSOR_ID_W +: LEVEL_W] !== want.level) begin
                        $error("level mismatch (sensor %0d): expected %0d, actual %0d",
                               want.sensor, want.level, m_tdata[SENSOR_ID_W +: LEVEL_W]);
                        errs++;
                    end
                    if (m_tdata[M_TDATA_W-1:SENSOR_ID_W+LEVEL_W] !== '0) begin
                        $error("tdata padding mismatch: expected %0d, actual %0d", 0,
                               m_tdata[M_TDATA_W-1:SENSOR_ID_W+LEVEL_W]);
                        errs++;
                    end
                end
            end
            // Predict the level for an accepted sample
            if (s_tvalid && s_tready) begin
                expected_levels.push_back(envelope_step(s_tdata[SENSOR_ID_W-1:0],
                                                        s_tdata[SENSOR_ID_W]));
            end
            // Track register writes; unknown indexes are dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MAX_INDEX:     max_idx_reg = cfg_data[INDEX_W-1:0];
                    REG_TIMEOUT_TICKS: timeout_reg = cfg_data[TIME_W-1:0];
                    REG_RISE_STEP:     step_reg    = cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
        end
        fail_count     <= fail_count + errs;
        levels_pending <= expected_levels.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// Top-level testbench for the sensor envelope unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import srte_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 700;
    localparam int STEADY_AFTER = 1400;
    localparam int NUM_PHASES   = 12;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int unsigned fail_count;
    int unsigned levels_pending;
    int unsigned samples_sent     = 0;
    int unsigned settings_written = 0;
    bit          steady           = 1'b0;
    bit          long_hold_done   = 1'b0;

    always #6 aclk = ~aclk;

    sensor_rise_timeout_envelope_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    srte_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .levels_pending (levels_pending)
    );

    // Offer one sample beat and hold it until taken; sometimes idle afterwards
    task automatic send_sample(input logic [SENSOR_ID_W-1:0] id, input logic is_high);
        s_tdata  <= {1'b0, is_high, id};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        samples_sent++;
        if (!steady && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every predicted level has come back
    task automatic drain_levels();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (levels_pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Write one register; the caller lowers cfg_valid after the last one
    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Load a full register setting while the unit is idle
    task automatic load_settings(input logic [CFG_DATA_W-1:0] max_d,
                                 input logic [CFG_DATA_W-1:0] tmo,
                                 input logic [CFG_DATA_W-1:0] stp,
                                 input bit                    with_spare,
                                 input logic [CFG_DATA_W-1:0] spare_d);
        drain_levels();
        put_reg(REG_MAX_INDEX, max_d);
        put_reg(REG_TIMEOUT_TICKS, tmo);
        put_reg(REG_RISE_STEP, stp);
        if (with_spare) begin
            put_reg(REG_SPARE, spare_d);
        end
        cfg_valid <= 1'b0;
        settings_written++;
    endtask

    // Level sink: random stalls, one long hold-off, then steady acceptance
    initial begin : level_sink
        wait (aresetn);
        forever begin
            if (!long_hold_done && samples_sent >= HOLD_AFTER) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                long_hold_done = 1'b1;
            end else if (steady || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
        end
    end

    // Hard limit on run time
    initial begin : watchdog
        #(10_000_000);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [SENSOR_ID_W-1:0] pool [4];
        int unsigned            pool_n;
        int unsigned            count;
        int unsigned            low_pct;
        logic [CFG_DATA_W-1:0]  max_d;
        logic [CFG_DATA_W-1:0]  tmo;
        logic [CFG_DATA_W-1:0]  stp;
        logic [SENSOR_ID_W-1:0] id;
        logic                   is_high;

        pool_n = 1;
        for (int i = 0; i < 4; i++) pool[i] = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Short ramp, saturating step: rise to full, hold index at the ramp end
        load_settings(16'h0003, 16'd5, 16'hFFFF, 1'b0, '0);
        repeat (5) send_sample(6'd63, 1'b1);
        send_sample(6'd0, 1'b1);
        // Lower the ramp end below a live index; also poke the unused register
        load_settings(16'h5A01, 16'hFFFF, 16'h0001, 1'b1, 16'hFFFF);
        repeat (2) send_sample(6'd63, 1'b1);
        send_sample(6'd63, 1'b0);
        send_sample(6'd0, 1'b0);
        send_sample(6'd0, 1'b1);
        // Zero ramp length, zero timeout, zero step
        load_settings(16'hA500, 16'h0000, 16'h0000, 1'b0, '0);
        repeat (3) send_sample(6'd7, 1'b1);
        send_sample(6'd7, 1'b0);
        send_sample(6'd7, 1'b1);

        // Random phases: a few busy sensors with mostly-high runs, plus noise
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    max_d = 16'hFFFF; tmo = 16'hFFFF; stp = 16'd300;
                    count = 300; low_pct = 0; pool_n = 1;
                end
                1: begin
                    // keep the same sensors so their long ramps sit past the new end
                    max_d = 16'hC301; tmo = 16'd2; stp = 16'd1;
                    count = 150; low_pct = 3;
                end
                2: begin
                    max_d = 16'h7F00; tmo = 16'd0; stp = 16'd0;
                    count = 60; low_pct = 15; pool_n = 4;
                end
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        max_d = 16'($urandom);
                    end else begin
                        max_d = {8'($urandom), 8'($urandom_range(1, 16))};
                    end
                    if ($urandom_range(0, 4) == 0) begin
                        tmo = 16'($urandom);
                    end else begin
                        tmo = 16'($urandom_range(0, 40));
                    end
                    if ($urandom_range(0, 1) == 0 && max_d[7:0] != 0) begin
                        stp = 16'(16'hFFFF / max_d[7:0]);
                    end else begin
                        stp = 16'($urandom);
                    end
                    count = 125; low_pct = $urandom_range(2, 20);
                    pool_n = $urandom_range(1, 4);
                end
            endcase
            load_settings(max_d, tmo, stp, $urandom_range(0, 2) == 0, 16'($urandom));
            if (ph != 1) begin
                for (int i = 0; i < 4; i++) pool[i] = 6'($urandom_range(0, 63));
            end
            for (int n = 0; n < count; n++) begin
                if (samples_sent >= STEADY_AFTER && long_hold_done) steady = 1'b1;
                if ($urandom_range(0, 99) < 10) begin
                    id      = 6'($urandom_range(0, 63));
                    is_high = 1'($urandom);
                end else begin
                    id      = pool[$urandom_range(0, pool_n - 1)];
                    is_high = $urandom_range(0, 99) >= low_pct;
                end
                send_sample(id, is_high);
            end
        end

        drain_levels();
        repeat (10) @(posedge aclk);
        $display("Covered %0d sensor samples across %0d register settings, incl. zero and",
                 samples_sent, settings_written);
        $display("full-width ramp/timeout/step, a %0d-cycle output hold-off and idle-free tail.",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
